// ----- src/cgrb_pkg.sv -----
// Shared types and constants for the clipped glyph row blitter.
// Depends on nothing; every other file of the block imports it.
package cgrb_pkg;

    // Default sizing of the glyph store
    localparam int DEF_MAX_GLYPH_HEIGHT = 16;
    localparam int DEF_MAX_ROW_BYTES    = 2;
    localparam int DEF_CODE_COUNT       = 256;

    // Rows given per character at most, and mask columns
    localparam int MAX_RESULTS = 16;
    localparam int MASK_W      = 16;
    localparam int COL_W       = $clog2(MASK_W + 1);

    // Signed width for exact (unwrapped) clip arithmetic
    localparam int GEO_W = 20;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 96;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLIP_LEFT       = 3'd0,
        CFG_CLIP_TOP        = 3'd1,
        CFG_CLIP_RIGHT      = 3'd2,
        CFG_CLIP_BOTTOM     = 3'd3,
        CFG_FONT_HEIGHT     = 3'd4,
        CFG_FONT_ASCENT     = 3'd5,
        CFG_GLYPH_ROW_BYTES = 3'd6,
        CFG_INK_COLOR       = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] clip_left;
        logic [15:0] clip_top;
        logic [15:0] clip_right;
        logic [15:0] clip_bottom;
        logic [4:0]  font_height;
        logic [4:0]  font_ascent;
        logic [1:0]  glyph_row_bytes;
        logic [23:0] ink_color;
    } cfg_t;

    // Controller -> datapath
    typedef struct packed {
        logic take_in;
        logic calc_base;
        logic read_width;
        logic latch_width;
        logic start_rows;
        logic issue;
        logic emit_row;
        logic emit_empty;
    } dp_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic rows_go;
        logic byte_last;
        logic row_last;
        logic out_free;
    } dp_sts_t;

endpackage

// ----- src/cgrb_ctrl.sv -----
// Sequencer of the glyph row blitter: walks one character through setup,
// the width read and the row reads. Uses cgrb_pkg command/status types.
module cgrb_ctrl
    import cgrb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    input  logic    s_tuser,
    output logic    s_tready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_BASE   = 9'b000000010,
        ST_WREAD  = 9'b000000100,
        ST_WLATCH = 9'b000001000,
        ST_BEGIN  = 9'b000010000,
        ST_ROW    = 9'b000100000,
        ST_ROWEND = 9'b001000000,
        ST_EMIT   = 9'b010000000,
        ST_EMPTY  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.take_in = 1'b1;
                    // loads finish in the accept cycle
                    if (s_tuser)
                        state_next = ST_BASE;
                end
            end
            ST_BASE:
            begin
                cmd.calc_base = 1'b1;
                state_next    = ST_WREAD;
            end
            ST_WREAD:
            begin
                cmd.read_width = 1'b1;
                state_next     = ST_WLATCH;
            end
            ST_WLATCH:
            begin
                cmd.latch_width = 1'b1;
                state_next      = ST_BEGIN;
            end
            ST_BEGIN:
            begin
                cmd.start_rows = 1'b1;
                state_next     = sts.rows_go ? ST_ROW : ST_EMPTY;
            end
            ST_ROW:
            begin
                cmd.issue = 1'b1;
                if (sts.byte_last)
                    state_next = ST_ROWEND;
            end
            ST_ROWEND:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_row = 1'b1;
                    state_next   = sts.row_last ? ST_IDLE : ST_ROW;
                end
            end
            ST_EMPTY:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_empty = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- src/cgrb_datapath.sv -----
// Datapath of the glyph row blitter: glyph store, pen, clip geometry,
// row byte capture, mask build and the output register. Uses cgrb_pkg.
module cgrb_datapath
    import cgrb_pkg::*;
#(
    parameter int MAX_GLYPH_HEIGHT = DEF_MAX_GLYPH_HEIGHT,
    parameter int MAX_ROW_BYTES    = DEF_MAX_ROW_BYTES,
    parameter int CODE_COUNT       = DEF_CODE_COUNT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  dp_cmd_t               cmd,
    output dp_sts_t               sts,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast
);

    localparam int STORE_DEPTH = CODE_COUNT * (1 + MAX_GLYPH_HEIGHT * MAX_ROW_BYTES);
    localparam int AW  = $clog2(STORE_DEPTH);
    localparam int HW  = $clog2(MAX_GLYPH_HEIGHT + 1);
    localparam int RBW = $clog2(MAX_ROW_BYTES + 1);
    localparam int BIW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int STW = $clog2(MAX_GLYPH_HEIGHT * MAX_ROW_BYTES + 2);
    localparam int NW  = $clog2(MAX_RESULTS);
    localparam int PW  = 8 + STW;
    localparam int OW  = HW + RBW;
    localparam logic signed [GEO_W-1:0] COL_LIMIT = GEO_W'(MASK_W);

    function automatic logic signed [GEO_W-1:0] sx16(input logic [15:0] v);
        return {{(GEO_W-16){v[15]}}, v};
    endfunction

    // Input fields
    logic [13:0] load_address;
    logic [7:0]  load_data;
    logic [7:0]  char_code;
    logic        new_string;
    logic [15:0] start_pen_x;
    logic [15:0] start_pen_y;

    assign load_address = s_tdata[13:0];
    assign load_data    = s_tdata[21:14];
    assign char_code    = s_tdata[29:22];
    assign new_string   = s_tdata[30];
    assign start_pen_x  = s_tdata[46:31];
    assign start_pen_y  = s_tdata[62:47];

    // Effective font geometry
    logic [HW-1:0]  h_eff;
    logic [RBW-1:0] rb_eff;
    logic [STW-1:0] stride_next;
    logic signed [GEO_W-1:0] h_ext;

    always_comb
    begin
        if (int'(cfg.font_height) > MAX_GLYPH_HEIGHT)
            h_eff = HW'(MAX_GLYPH_HEIGHT);
        else
            h_eff = HW'(cfg.font_height);

        if (cfg.glyph_row_bytes == 2'd0)
            rb_eff = RBW'(1);
        else if (int'(cfg.glyph_row_bytes) > MAX_ROW_BYTES)
            rb_eff = RBW'(MAX_ROW_BYTES);
        else
            rb_eff = RBW'(cfg.glyph_row_bytes);
    end

    assign stride_next = STW'(int'(h_eff) * int'(rb_eff) + 1);
    assign h_ext       = $signed({{(GEO_W-HW){1'b0}}, h_eff});

    // Registers
    logic [15:0]             pen_x_reg;
    logic [15:0]             pen_y_reg;
    logic [7:0]              code_reg;
    logic                    oob_reg;
    logic [STW-1:0]          stride_reg;
    logic [AW-1:0]           base_reg;
    logic signed [GEO_W-1:0] top_reg;
    logic signed [GEO_W-1:0] clpx_reg;
    logic signed [GEO_W-1:0] crpx_reg;
    logic [HW-1:0]           te_reg;
    logic [HW-1:0]           bsat_reg;
    logic [HW-1:0]           be_reg;
    logic [COL_W-1:0]        left_reg;
    logic [COL_W-1:0]        right_reg;
    logic [7:0]              w_reg;
    logic [15:0]             after_reg;
    logic                    vis_reg;
    logic [OW-1:0]           rowoff_reg;
    logic [HW-1:0]           y_reg;
    logic [NW-1:0]           n_reg;
    logic [AW-1:0]           rd_ptr_reg;
    logic [BIW-1:0]          bi_reg;
    logic                    cap_en_reg;
    logic [BIW-1:0]          cap_idx_reg;
    logic [7:0]              row_bytes_reg [MAX_ROW_BYTES];
    logic [7:0]              rd_data_reg;

    logic                    m_valid_reg;
    logic                    o_row_valid_reg;
    logic [15:0]             o_row_y_reg;
    logic [15:0]             o_row_x_reg;
    logic [MASK_W-1:0]       o_mask_reg;
    logic [7:0]              o_width_reg;
    logic [15:0]             o_after_reg;
    logic [23:0]             o_color_reg;
    logic                    o_last_reg;

    // Glyph store: one write port for loads, one registered read port
    logic [7:0]    store_mem [STORE_DEPTH];
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    assign wr_en   = cmd.take_in && !s_tuser && (int'(load_address) < STORE_DEPTH);
    assign wr_addr = AW'(load_address);
    assign rd_en   = cmd.read_width || cmd.issue;
    assign rd_addr = cmd.read_width ? base_reg : rd_ptr_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_addr] <= load_data;
        if (rd_en)
            rd_data_reg <= store_mem[rd_addr];
    end

    // Combinational pieces
    logic [PW-1:0]           base_prod;
    logic [7:0]              w_cur;
    logic signed [GEO_W-1:0] w_ext;
    logic signed [GEO_W-1:0] te_raw;
    logic signed [GEO_W-1:0] b_raw;
    logic signed [GEO_W-1:0] rsel;
    logic [HW-1:0]           te_sat;
    logic [HW-1:0]           b_sat;
    logic [COL_W-1:0]        left_sat;
    logic [COL_W-1:0]        right_sat;
    logic [OW-1:0]           rowoff_next;
    logic [MASK_W-1:0]       mask_comb;
    logic                    row_last;

    assign base_prod = {{STW{1'b0}}, code_reg} * {8'b0, stride_reg};
    assign w_cur     = oob_reg ? 8'd0 : rd_data_reg;
    assign w_ext     = $signed({{(GEO_W-8){1'b0}}, w_cur});
    assign te_raw    = sx16(cfg.clip_top) - top_reg;
    assign b_raw     = top_reg + h_ext - sx16(cfg.clip_bottom) + GEO_W'(1);
    assign rsel      = (w_ext > crpx_reg) ? crpx_reg : w_ext;
    assign rowoff_next = {{RBW{1'b0}}, te_reg} * {{HW{1'b0}}, rb_eff};

    always_comb
    begin
        if (te_raw[GEO_W-1])
            te_sat = '0;
        else if (te_raw > h_ext)
            te_sat = h_eff;
        else
            te_sat = HW'(te_raw);

        if (b_raw[GEO_W-1])
            b_sat = '0;
        else if (b_raw > h_ext)
            b_sat = h_eff;
        else
            b_sat = HW'(b_raw);

        if (clpx_reg[GEO_W-1])
            left_sat = '0;
        else if (clpx_reg > COL_LIMIT)
            left_sat = COL_W'(MASK_W);
        else
            left_sat = COL_W'(clpx_reg);

        if (rsel[GEO_W-1])
            right_sat = '0;
        else if (rsel > COL_LIMIT)
            right_sat = COL_W'(MASK_W);
        else
            right_sat = COL_W'(rsel);
    end

    // Column x takes bit (7 - x mod 8) of row byte x / 8
    for (genvar gx = 0; gx < MASK_W; gx++)
    begin : g_mask
        localparam int BYTE_IDX = gx / 8;
        if (BYTE_IDX < MAX_ROW_BYTES)
        begin : g_col
            assign mask_comb[gx] = (int'(rb_eff) > BYTE_IDX)
                                   && (COL_W'(gx) >= left_reg)
                                   && (COL_W'(gx) < right_reg)
                                   && row_bytes_reg[BYTE_IDX][7 - (gx % 8)];
        end
        else
        begin : g_none
            assign mask_comb[gx] = 1'b0;
        end
    end

    assign row_last = ((({1'b0, y_reg}) + (HW+1)'(1)) >= {1'b0, be_reg})
                      || (n_reg == NW'(MAX_RESULTS - 1));

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg   <= '0;
            pen_y_reg   <= '0;
            y_reg       <= '0;
            n_reg       <= '0;
            bi_reg      <= '0;
            cap_en_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            cap_en_reg <= cmd.issue;

            if (cmd.take_in && s_tuser && new_string)
            begin
                pen_x_reg <= start_pen_x;
                pen_y_reg <= start_pen_y;
            end
            else if ((cmd.emit_row && row_last) || cmd.emit_empty)
            begin
                pen_x_reg <= after_reg;
            end

            if (cmd.start_rows)
            begin
                y_reg  <= te_reg;
                n_reg  <= '0;
                bi_reg <= '0;
            end
            else if (cmd.issue)
            begin
                bi_reg <= bi_reg + BIW'(1);
            end
            else if (cmd.emit_row)
            begin
                y_reg  <= y_reg + HW'(1);
                n_reg  <= n_reg + NW'(1);
                bi_reg <= '0;
            end

            if (cmd.emit_row || cmd.emit_empty)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            code_reg   <= char_code;
            oob_reg    <= (int'(char_code) >= CODE_COUNT);
            stride_reg <= stride_next;
        end

        if (cmd.calc_base)
        begin
            base_reg <= AW'(base_prod);
            top_reg  <= sx16(pen_y_reg) - $signed({{(GEO_W-5){1'b0}}, cfg.font_ascent});
            clpx_reg <= sx16(cfg.clip_left) - sx16(pen_x_reg);
            crpx_reg <= sx16(cfg.clip_right) - sx16(pen_x_reg);
        end

        if (cmd.read_width)
        begin
            te_reg   <= te_sat;
            bsat_reg <= b_sat;
            left_reg <= left_sat;
        end

        if (cmd.latch_width)
        begin
            w_reg      <= w_cur;
            after_reg  <= pen_x_reg + {8'b0, w_cur};
            // px + w >= clip_left and px < clip_right
            vis_reg    <= (w_ext >= clpx_reg) && !crpx_reg[GEO_W-1] && (crpx_reg != '0);
            right_reg  <= right_sat;
            be_reg     <= h_eff - bsat_reg;
            rowoff_reg <= rowoff_next;
        end

        // rows are contiguous in the store, so the pointer just counts up
        if (cmd.start_rows)
            rd_ptr_reg <= base_reg + AW'(1) + AW'(rowoff_reg);
        else if (cmd.issue)
            rd_ptr_reg <= rd_ptr_reg + AW'(1);

        if (cmd.issue)
            cap_idx_reg <= bi_reg;

        if (cap_en_reg)
            row_bytes_reg[cap_idx_reg] <= oob_reg ? 8'd0 : rd_data_reg;

        if (cmd.emit_row || cmd.emit_empty)
        begin
            o_row_x_reg <= pen_x_reg;
            o_width_reg <= w_reg;
            o_after_reg <= after_reg;
            o_color_reg <= cfg.ink_color;
        end

        if (cmd.emit_row)
        begin
            o_row_valid_reg <= 1'b1;
            o_row_y_reg     <= 16'(top_reg + $signed({{(GEO_W-HW){1'b0}}, y_reg}));
            o_mask_reg      <= mask_comb;
            o_last_reg      <= row_last;
        end
        else if (cmd.emit_empty)
        begin
            o_row_valid_reg <= 1'b0;
            o_row_y_reg     <= '0;
            o_mask_reg      <= '0;
            o_last_reg      <= 1'b1;
        end
    end

    assign sts.rows_go   = vis_reg && (te_reg < be_reg);
    assign sts.byte_last = ((RBW+1)'(bi_reg) + (RBW+1)'(1)) == (RBW+1)'(rb_eff);
    assign sts.row_last  = row_last;
    assign sts.out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_row_valid_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {o_color_reg, o_after_reg, o_width_reg, o_mask_reg,
                       o_row_x_reg, o_row_y_reg};

endmodule

// ----- src/clipped_glyph_row_blitter.sv -----
// Top level of the clipped glyph row blitter: configuration registers,
// sequencer and datapath. Depends on cgrb_pkg, cgrb_ctrl, cgrb_datapath.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-----------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | s_tuser=func, s_tdata=load/draw fields
//  m_*      | out | m_tvalid/m_tready  | m_tuser=row_valid, m_tlast=last, m_tdata
//  cfg_*    | in  | cfg_we, no stall   | cfg_index selects register, cfg_data
//
// A load completes in its accept cycle; loads can follow each other every cycle.
// A draw computes base and clip geometry, reads and latches the width, then
// reads and emits each visible row, or emits one empty result when no row is
// visible; the single read port of the glyph store reads one byte per cycle.
// A result waits in the output register; the sequencer stalls there while it
// is not taken. Reset clears the pen and control registers, not the glyph store.
module clipped_glyph_row_blitter
    import cgrb_pkg::*;
#(
    parameter int MAX_GLYPH_HEIGHT = DEF_MAX_GLYPH_HEIGHT,
    parameter int MAX_ROW_BYTES    = DEF_MAX_ROW_BYTES,
    parameter int CODE_COUNT       = DEF_CODE_COUNT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // load_address[13:0], load_data[21:14], char_code[29:22], new_string[30],
    // start_pen_x[46:31], start_pen_y[62:47], zero[63]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // func
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // row_y[15:0], row_x[31:16], row_mask[47:32], glyph_width[55:48],
    // pen_x_after[71:56], pixel_color[95:72]
    output logic [OUT_DATA_W-1:0] m_tdata,
    // row_valid
    output logic                  m_tuser,
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg_reg;
    dp_cmd_t cmd;
    dp_sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clip_left       <= 16'd0;
            cfg_reg.clip_top        <= 16'd0;
            cfg_reg.clip_right      <= 16'd32767;
            cfg_reg.clip_bottom     <= 16'd32767;
            cfg_reg.font_height     <= 5'd16;
            cfg_reg.font_ascent     <= 5'd12;
            cfg_reg.glyph_row_bytes <= 2'd2;
            cfg_reg.ink_color       <= 24'hFFFFFF;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_CLIP_LEFT:       cfg_reg.clip_left       <= cfg_data[15:0];
                CFG_CLIP_TOP:        cfg_reg.clip_top        <= cfg_data[15:0];
                CFG_CLIP_RIGHT:      cfg_reg.clip_right      <= cfg_data[15:0];
                CFG_CLIP_BOTTOM:     cfg_reg.clip_bottom     <= cfg_data[15:0];
                CFG_FONT_HEIGHT:     cfg_reg.font_height     <= cfg_data[4:0];
                CFG_FONT_ASCENT:     cfg_reg.font_ascent     <= cfg_data[4:0];
                CFG_GLYPH_ROW_BYTES: cfg_reg.glyph_row_bytes <= cfg_data[1:0];
                CFG_INK_COLOR:       cfg_reg.ink_color       <= cfg_data;
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    cgrb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cgrb_datapath #(
        .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT),
        .MAX_ROW_BYTES    (MAX_ROW_BYTES),
        .CODE_COUNT       (CODE_COUNT)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    // a result is only loaded into a free output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_row || cmd.emit_empty) |-> (!m_tvalid || m_tready))
        else $error("result loaded over a pending transfer");

    // a load leaves the block ready for the next item
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tuser) |=> s_tready)
        else $error("load did not return to ready");

    // a draw occupies the block past its accept cycle
    a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser) |=> !s_tready)
        else $error("draw accepted without leaving idle");

    // an empty result is the only result of its character and carries no mask
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tlast && (m_tdata[47:32] == '0)))
        else $error("empty result not final or mask not clear");
`endif

endmodule
